### rtl/mhc_pkg.sv
`default_nettype none

package mhc_pkg;

  // Array size and counter width
  localparam int unsigned MOTORS    = 32;
  localparam int unsigned TIME_BITS = 16;

  // Index width of the active motor (at least one bit)
  localparam int unsigned IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // Field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned MIDX_W     = 8;
  localparam int unsigned TO_W       = 16;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned LVL_IDX_W  = $clog2(LEVEL_W);
  localparam int unsigned DRIVE_W    = 32;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned FILT_W     = 16;

  // Effective motor count must also hold MOTORS itself
  localparam int unsigned EFF_W = ($clog2(MOTORS + 1) > CNT_W) ? $clog2(MOTORS + 1) : CNT_W;

  // Config port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MOTOR_COUNT     = 3'd0;
  localparam cfg_idx_t CFG_DEFAULT_TIMEOUT = 3'd1;
  localparam cfg_idx_t CFG_HOME_FILTER     = 3'd2;
  localparam cfg_idx_t CFG_OUTPUT_HIGH     = 3'd3;
  localparam cfg_idx_t CFG_HOME_LOW        = 3'd4;

  // Command codes; code 3 is unused and ignored
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_START = 2'd1;
  localparam func_t FUNC_STOP  = 2'd2;

  localparam logic [TO_W-1:0] MIN_REQUEST = TO_W'(250);

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_RUNNING   = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NOT_HOME  = 3'd3,
    ST_CONFIRMED = 3'd4,
    ST_TIMED_OUT = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAVE  = 2'd1,
    PH_RETURN = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CNT_W-1:0]  motor_count;
    logic [TO_W-1:0]   default_timeout;
    logic [FILT_W-1:0] home_filter;
    logic              output_high;
    logic              home_low;
  } cfg_t;

  typedef struct packed {
    phase_e               phase;
    logic [IDX_W-1:0]     active_index;
    logic                 running;
    logic                 last_home;
    logic [TIME_BITS-1:0] since_start;
    logic [TIME_BITS-1:0] since_change;
    logic [TO_W-1:0]      cycle_timeout;
    status_e              status;
  } ctl_state_t;

endpackage

`default_nettype wire

### rtl/mhc_if.sv
`default_nettype none

interface mhc_in_if;
  logic                               valid;
  logic                               ready;
  logic [mhc_pkg::FUNC_W-1:0]         func;
  logic [mhc_pkg::MIDX_W-1:0]         motor_index;
  logic [mhc_pkg::TO_W-1:0]           timeout_ms;
  logic [mhc_pkg::LEVEL_W-1:0]        home_levels;

  modport source(output valid, func, motor_index, timeout_ms, home_levels, input ready);
  modport sink(input valid, func, motor_index, timeout_ms, home_levels, output ready);
endinterface

interface mhc_out_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         status;
  logic [mhc_pkg::DRIVE_W-1:0]        drive_levels;
  logic                               drive_enable;
  logic [1:0]                         cycle_phase;

  modport source(output valid, status, drive_levels, drive_enable, cycle_phase, input ready);
  modport sink(input valid, status, drive_levels, drive_enable, cycle_phase, output ready);
endinterface

`default_nettype wire

### rtl/mhc_core.sv
`default_nettype none

module mhc_core (
  input  var mhc_pkg::cfg_t                  cfg_i,
  input  var mhc_pkg::ctl_state_t            state_i,
  input  wire logic [mhc_pkg::FUNC_W-1:0]    func_i,
  input  wire logic [mhc_pkg::MIDX_W-1:0]    motor_index_i,
  input  wire logic [mhc_pkg::TO_W-1:0]      timeout_ms_i,
  input  wire logic [mhc_pkg::LEVEL_W-1:0]   home_levels_i,
  output var mhc_pkg::ctl_state_t            state_o,
  output wire logic [mhc_pkg::DRIVE_W-1:0]   drive_levels_o
);

  function automatic logic level_at(input logic [mhc_pkg::LEVEL_W-1:0] levels,
                                    input logic [mhc_pkg::MIDX_W-1:0]  idx);
    logic bit_v;
    bit_v = 1'b0;
    if (idx < mhc_pkg::MIDX_W'(mhc_pkg::LEVEL_W)) begin
      bit_v = levels[idx[mhc_pkg::LVL_IDX_W-1:0]];
    end
    return bit_v;
  endfunction

  function automatic logic [mhc_pkg::TIME_BITS-1:0] sat_inc(
      input logic [mhc_pkg::TIME_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  logic [mhc_pkg::EFF_W-1:0]  eff_count;
  logic [mhc_pkg::MIDX_W-1:0] active_wide;
  logic                       start_home;
  logic                       tick_home;
  logic [mhc_pkg::MOTORS-1:0] onehot;

  assign eff_count = (mhc_pkg::EFF_W'(cfg_i.motor_count) > mhc_pkg::EFF_W'(mhc_pkg::MOTORS))
                   ? mhc_pkg::EFF_W'(mhc_pkg::MOTORS)
                   : mhc_pkg::EFF_W'(cfg_i.motor_count);
  assign active_wide = mhc_pkg::MIDX_W'(state_i.active_index);
  assign start_home  = level_at(home_levels_i, motor_index_i) ^ cfg_i.home_low;
  assign tick_home   = level_at(home_levels_i, active_wide) ^ cfg_i.home_low;

  always_comb begin
    logic done;
    state_o = state_i;
    done    = 1'b0;
    case (func_i)
      mhc_pkg::FUNC_START: begin
        if (motor_index_i >= mhc_pkg::MIDX_W'(eff_count)) begin
          state_o.status = mhc_pkg::ST_INVALID;
        end else if (!start_home) begin
          state_o.status = mhc_pkg::ST_NOT_HOME;
        end else begin
          state_o.active_index  = motor_index_i[mhc_pkg::IDX_W-1:0];
          state_o.cycle_timeout = (timeout_ms_i >= mhc_pkg::MIN_REQUEST)
                                ? timeout_ms_i : cfg_i.default_timeout;
          state_o.since_start   = '0;
          state_o.since_change  = '0;
          state_o.last_home     = 1'b1;
          state_o.phase         = mhc_pkg::PH_LEAVE;
          state_o.running       = 1'b1;
          state_o.status        = mhc_pkg::ST_RUNNING;
        end
      end
      mhc_pkg::FUNC_STOP: begin
        state_o.running = 1'b0;
        state_o.phase   = mhc_pkg::PH_IDLE;
        if (state_i.status == mhc_pkg::ST_RUNNING) begin
          state_o.status = mhc_pkg::ST_IDLE;
        end
      end
      mhc_pkg::FUNC_TICK: begin
        if (state_i.status == mhc_pkg::ST_RUNNING
            && active_wide < mhc_pkg::MIDX_W'(eff_count)) begin
          state_o.since_start  = sat_inc(state_i.since_start);
          state_o.since_change = sat_inc(state_i.since_change);
          if (tick_home != state_i.last_home) begin
            state_o.last_home    = tick_home;
            state_o.since_change = '0;
          end
          // debounced level decides the phase step
          if (state_o.since_change >= cfg_i.home_filter) begin
            if (state_i.phase == mhc_pkg::PH_LEAVE && !tick_home) begin
              state_o.phase = mhc_pkg::PH_RETURN;
            end else if (state_i.phase == mhc_pkg::PH_RETURN && tick_home) begin
              state_o.running = 1'b0;
              state_o.phase   = mhc_pkg::PH_IDLE;
              state_o.status  = mhc_pkg::ST_CONFIRMED;
              done            = 1'b1;
            end
          end
          if (!done && state_o.since_start >= state_i.cycle_timeout) begin
            state_o.running = 1'b0;
            state_o.phase   = mhc_pkg::PH_IDLE;
            state_o.status  = mhc_pkg::ST_TIMED_OUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // one-hot drive of the running motor, polarity over all MOTORS bits
  always_comb begin
    onehot = '0;
    if (state_o.running) begin
      onehot[state_o.active_index] = 1'b1;
    end
    if (!cfg_i.output_high) begin
      onehot = ~onehot;
    end
  end

  assign drive_levels_o = mhc_pkg::DRIVE_W'(onehot);

endmodule

`default_nettype wire

### rtl/motor_home_cycle_controller_unit.sv
// Motor home cycle controller.
// Input channel in_i carries one command per transfer: a 1 ms tick, a start
// (motor index, requested timeout) or a stop, each with the raw home switch
// levels. Output channel out_o returns exactly one result per command: the
// status, the polarity-adjusted one-hot drive word, the drive enable and the
// cycle phase, all taken after that command has been applied.
// Configuration (motor count, default timeout, home filter, polarities) is
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one register per cycle.
// The user writes it only while no command is in flight; the block does not enforce this.
// Unknown indexes are dropped. An accepted command is held in the input stage
// and, once the result register is free, processed into the result register.
// Throughput: one command per cycle while out_o does not stall; the controller
// state updates through the combinational next-state logic in mhc_core.
// Reset clears the cycle state to idle and loads the configuration defaults
// (32 motors, 5000 ms, 20 ms filter, active-high drive, active-low switch).
// When out_o stalls, the held result and one staged command fill up; after
// that in_i.ready drops until the result is transferred.
`default_nettype none

module motor_home_cycle_controller_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  mhc_in_if.sink                                   in_i,
  mhc_out_if.source                                out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [mhc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mhc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  // configuration registers
  mhc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_count     <= mhc_pkg::CNT_W'(32);
      cfg_q.default_timeout <= mhc_pkg::TO_W'(5000);
      cfg_q.home_filter     <= mhc_pkg::FILT_W'(20);
      cfg_q.output_high     <= 1'b1;
      cfg_q.home_low        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mhc_pkg::CFG_MOTOR_COUNT:     cfg_q.motor_count <= cfg_wdata_i[mhc_pkg::CNT_W-1:0];
        mhc_pkg::CFG_DEFAULT_TIMEOUT: cfg_q.default_timeout <= cfg_wdata_i[mhc_pkg::TO_W-1:0];
        mhc_pkg::CFG_HOME_FILTER:     cfg_q.home_filter <= cfg_wdata_i[mhc_pkg::FILT_W-1:0];
        mhc_pkg::CFG_OUTPUT_HIGH:     cfg_q.output_high <= cfg_wdata_i[0];
        mhc_pkg::CFG_HOME_LOW:        cfg_q.home_low <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // input stage
  logic                             in_valid_q;
  logic [mhc_pkg::FUNC_W-1:0]       func_q;
  logic [mhc_pkg::MIDX_W-1:0]       motor_index_q;
  logic [mhc_pkg::TO_W-1:0]         timeout_ms_q;
  logic [mhc_pkg::LEVEL_W-1:0]      home_levels_q;

  // result stage
  logic                             out_valid_q;
  logic [2:0]                       status_q;
  logic [mhc_pkg::DRIVE_W-1:0]      drive_levels_q;
  logic                             drive_enable_q;
  logic [1:0]                       cycle_phase_q;

  mhc_pkg::ctl_state_t              state_q;
  mhc_pkg::ctl_state_t              state_d;
  logic [mhc_pkg::DRIVE_W-1:0]      drive_levels_d;

  logic out_free;
  logic proc_fire;
  logic in_fire;

  // result register can take a new value when empty or being drained
  assign out_free  = !out_valid_q || out_o.ready;
  assign proc_fire = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q        <= in_i.func;
      motor_index_q <= in_i.motor_index;
      timeout_ms_q  <= in_i.timeout_ms;
      home_levels_q <= in_i.home_levels;
    end
  end

  mhc_core u_core (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .func_i         (func_q),
    .motor_index_i  (motor_index_q),
    .timeout_ms_i   (timeout_ms_q),
    .home_levels_i  (home_levels_q),
    .state_o        (state_d),
    .drive_levels_o (drive_levels_d)
  );

  // cycle state advances once per processed command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= mhc_pkg::PH_IDLE;
      state_q.active_index  <= '0;
      state_q.running       <= 1'b0;
      state_q.last_home     <= 1'b0;
      state_q.since_start   <= '0;
      state_q.since_change  <= '0;
      state_q.cycle_timeout <= '0;
      state_q.status        <= mhc_pkg::ST_IDLE;
    end else if (proc_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (proc_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      status_q       <= state_d.status;
      drive_levels_q <= drive_levels_d;
      drive_enable_q <= state_d.running;
      cycle_phase_q  <= state_d.phase;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.drive_levels = drive_levels_q;
  assign out_o.drive_enable = drive_enable_q;
  assign out_o.cycle_phase  = cycle_phase_q;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import mhc_pkg::*;

  // Codes the package leaves unnamed: the unused command and a register slot
  // the block drops.
  localparam func_t    FUNC_NONE  = 2'd3;
  localparam cfg_idx_t CFG_UNUSED = 3'd7;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_CMDS = 1040;

  typedef struct {
    func_t               func;
    logic [MIDX_W-1:0]   idx;
    logic [TO_W-1:0]     tmo;
    logic [LEVEL_W-1:0]  levels;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [DRIVE_W-1:0]  drive;
    logic                en;
    logic [1:0]          phase;
  } report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mhc_in_if  in_ch ();
  mhc_out_if out_ch ();

  motor_home_cycle_controller_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Commands waiting for the driver, and the reports each accepted command
  // must produce, oldest first.
  cmd_t    cmd_backlog[$];
  report_t reports_due[$];

  int  cycles;
  int  mismatches;
  int  queued;
  bit  in_taken;      // set at the edge that completes an input transfer
  bit  quiet;         // no gaps or stalls at all while set
  int  in_gap, in_calm;
  int  out_stall, out_calm;
  cmd_t next_cmd;
  cmd_t arrived;

  // Controller settings as the block holds them (reset values)
  logic [CNT_W-1:0]  cfg_count    = 6'd32;
  logic [TO_W-1:0]   cfg_def_tmo  = 16'd5000;
  logic [FILT_W-1:0] cfg_filter   = 16'd20;
  logic              cfg_out_high = 1'b1;
  logic              cfg_home_low = 1'b1;

  // Cycle state of the controller (reset values)
  phase_e                ctl_phase      = PH_IDLE;
  logic [IDX_W-1:0]      ctl_act        = '0;
  logic                  ctl_run        = 1'b0;
  logic                  ctl_last_home  = 1'b0;
  logic [TIME_BITS-1:0]  ctl_since_start = '0;
  logic [TIME_BITS-1:0]  ctl_since_chg  = '0;
  logic [TO_W-1:0]       ctl_tmo        = '0;
  status_e               ctl_status     = ST_IDLE;

  // ---------------------------------------------------------------------
  // Controller prediction
  // ---------------------------------------------------------------------

  // Motors fitted, clipped to the array size.
  function automatic int fitted();
    return (int'(cfg_count) > int'(MOTORS)) ? int'(MOTORS) : int'(cfg_count);
  endfunction

  // Debounce input: is motor m at home right now? Motors past the count and
  // motors without a switch bit never read home.
  function automatic bit switch_home(int m, logic [LEVEL_W-1:0] lv);
    bit raw;
    raw = (m < int'(LEVEL_W)) ? lv[m] : 1'b0;
    if (m >= fitted()) return 1'b0;
    return cfg_home_low ? !raw : raw;
  endfunction

  function automatic logic [TIME_BITS-1:0] bump(logic [TIME_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void halt_cycle();
    ctl_run   = 1'b0;
    ctl_phase = PH_IDLE;
    if (ctl_status == ST_RUNNING) ctl_status = ST_IDLE;
  endfunction

  // Applies one command to the cycle state and returns the report it yields.
  function automatic report_t advance_controller(cmd_t c);
    report_t r;
    bit home;
    bit done;
    int m;
    logic [DRIVE_W-1:0] drv;
    done = 1'b0;
    m = int'(c.idx);
    case (c.func)
      FUNC_START: begin
        if (m >= fitted()) begin
          ctl_status = ST_INVALID;
        end else if (!switch_home(m, c.levels)) begin
          ctl_status = ST_NOT_HOME;
        end else begin
          // accepted: a running cycle on another motor is simply replaced
          ctl_act         = c.idx[IDX_W-1:0];
          ctl_tmo         = (c.tmo >= MIN_REQUEST) ? c.tmo : cfg_def_tmo;
          ctl_since_start = '0;
          ctl_since_chg   = '0;
          ctl_last_home   = 1'b1;
          ctl_phase       = PH_LEAVE;
          ctl_run         = 1'b1;
          ctl_status      = ST_RUNNING;
        end
      end
      FUNC_STOP: halt_cycle();
      FUNC_TICK: begin
        // ticks only count for a running status and a motor still fitted
        if (ctl_status == ST_RUNNING && int'(ctl_act) < fitted()) begin
          home = switch_home(int'(ctl_act), c.levels);
          ctl_since_start = bump(ctl_since_start);
          ctl_since_chg   = bump(ctl_since_chg);
          if (home != ctl_last_home) begin
            ctl_last_home = home;
            ctl_since_chg = '0;
          end
          if (ctl_since_chg >= cfg_filter) begin
            if (ctl_phase == PH_LEAVE && !home) begin
              ctl_phase = PH_RETURN;
            end else if (ctl_phase == PH_RETURN && home) begin
              halt_cycle();
              ctl_status = ST_CONFIRMED;
              done = 1'b1;
            end
          end
          if (!done && ctl_since_start >= ctl_tmo) begin
            halt_cycle();
            ctl_status = ST_TIMED_OUT;
          end
        end
      end
      default: ;  // unused code: state untouched
    endcase
    drv = ctl_run ? (DRIVE_W'(1) << ctl_act) : '0;
    if (!cfg_out_high) drv = ~drv;  // all MOTORS bits flip, idle too
    r.status = ctl_status;
    r.drive  = drv;
    r.en     = ctl_run;
    r.phase  = ctl_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, gaps
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (quiet) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // ---------------------------------------------------------------------
  // Command driver: changes the input channel on the falling edge only.
  // A command stays up until its transfer is seen, then the next one (or a
  // gap) follows.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          next_cmd = cmd_backlog.pop_front();
          in_ch.func        <= next_cmd.func;
          in_ch.motor_index <= next_cmd.idx;
          in_ch.timeout_ms  <= next_cmd.tmo;
          in_ch.home_levels <= next_cmd.levels;
          in_ch.valid       <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: on each rising edge check a result transfer against the oldest
  // prediction, then predict for a command transfer. A result can never
  // belong to a command taken at the same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    report_t want;
    if (rst_n) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d reports outstanding",
                 cycles, reports_due.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          if (reports_due.size() == 0) begin
            if (mismatches < 10)
              $display("cycle %0d: result with nothing outstanding", cycles);
            mismatches++;
          end else begin
            want = reports_due.pop_front();
            if (out_ch.status !== want.status || out_ch.drive_levels !== want.drive ||
                out_ch.drive_enable !== want.en || out_ch.cycle_phase !== want.phase) begin
              if (mismatches < 10) begin
                $write("cycle %0d: exp st %0d drv %h en %b ph %0d, ", cycles,
                       want.status, want.drive, want.en, want.phase);
                $display("got st %0d drv %h en %b ph %0d", out_ch.status,
                         out_ch.drive_levels, out_ch.drive_enable, out_ch.cycle_phase);
              end
              mismatches++;
            end
          end
        end
        if (in_ch.valid && in_ch.ready) begin
          in_taken = 1'b1;
          arrived.func   = in_ch.func;
          arrived.idx    = in_ch.motor_index;
          arrived.tmo    = in_ch.timeout_ms;
          arrived.levels = in_ch.home_levels;
          reports_due.push_back(advance_controller(arrived));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_cmd(func_t f, int m, int tmo, logic [LEVEL_W-1:0] lv);
    cmd_t c;
    c.func   = f;
    c.idx    = MIDX_W'(m);
    c.tmo    = TO_W'(tmo);
    c.levels = lv;
    cmd_backlog.push_back(c);
    queued++;
  endtask

  // Random switch levels with motor m forced to the wanted home state.
  function automatic logic [LEVEL_W-1:0] levels_for(int m, bit home);
    logic [LEVEL_W-1:0] lv;
    lv = $urandom;
    if (m < int'(LEVEL_W)) lv[m] = cfg_home_low ? !home : home;
    return lv;
  endfunction

  function automatic int request_tmo();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 249);   // falls back to the default
      1:       return 250;
      2:       return $urandom_range(250, 400);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Register write; no command is in flight when this runs, so the predicted
  // settings can follow at once.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MOTOR_COUNT:     cfg_count    = data[CNT_W-1:0];
      CFG_DEFAULT_TIMEOUT: cfg_def_tmo  = data[TO_W-1:0];
      CFG_HOME_FILTER:     cfg_filter   = data[FILT_W-1:0];
      CFG_OUTPUT_HIGH:     cfg_out_high = data[0];
      CFG_HOME_LOW:        cfg_home_low = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued command is taken and reported, then let the pipeline settle.
  task automatic drain();
    while (cmd_backlog.size() > 0 || in_ch.valid || reports_due.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] d;
    int r;
    d = $urandom;
    r = $urandom_range(0, 9);
    d[CNT_W-1:0] = (r == 0) ? 6'd0 : (r == 1) ? 6'd1 : (r == 2) ? 6'd32 :
                   (r == 3) ? 6'd63 : CNT_W'($urandom_range(2, 32));
    write_reg(CFG_MOTOR_COUNT, d);
    r = $urandom_range(0, 9);
    d = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
        (r < 6) ? 16'($urandom_range(1, 60)) : 16'($urandom_range(250, 600));
    write_reg(CFG_DEFAULT_TIMEOUT, d);
    r = $urandom_range(0, 9);
    d = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd20 :
        16'($urandom_range(1, 6));
    write_reg(CFG_HOME_FILTER, d);
    write_reg(CFG_OUTPUT_HIGH, 16'($urandom));
    write_reg(CFG_HOME_LOW, 16'($urandom));
  endtask

  // One start-leave-return cycle with random other switch bits; sometimes a
  // bounce while away, a stop, or a fresh start in the middle.
  task automatic queue_home_cycle();
    int m, lim, stay, away, back, bounce, k;
    m = (fitted() > 0) ? $urandom_range(0, fitted() - 1) : 0;
    // past the filter only matters up to a point; huge filters just time out
    lim = (int'(cfg_filter) < 30) ? int'(cfg_filter) : 30;
    stay = $urandom_range(0, 3);
    away = lim + $urandom_range(0, 3);
    back = lim + $urandom_range(0, 3);
    bounce = ($urandom_range(0, 5) == 0) ? $urandom_range(0, away) : -1;
    queue_cmd(FUNC_START, m, request_tmo(), levels_for(m, 1'b1));
    for (k = 0; k < stay; k++) queue_cmd(FUNC_TICK, 0, $urandom, levels_for(m, 1'b1));
    for (k = 0; k < away; k++)
      queue_cmd(FUNC_TICK, $urandom, $urandom, levels_for(m, k == bounce));
    case ($urandom_range(0, 9))
      0: queue_cmd(FUNC_STOP, $urandom, $urandom, $urandom);
      1: begin
        k = (fitted() > 0) ? $urandom_range(0, fitted() - 1) : 0;
        queue_cmd(FUNC_START, k, request_tmo(), levels_for(k, 1'b1));
      end
      default: ;
    endcase
    for (k = 0; k < back; k++) queue_cmd(FUNC_TICK, $urandom, $urandom, levels_for(m, 1'b1));
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int phase_end, m, k;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_TICK;
    in_ch.motor_index = '0;
    in_ch.timeout_ms  = '0;
    in_ch.home_levels = '0;
    out_ch.ready      = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset settings: 32 motors, active-low switches.
    queue_cmd(FUNC_TICK, 0, 0, 32'h0);                 // idle tick
    queue_cmd(FUNC_NONE, 255, 65535, 32'hFFFF_FFFF);   // unused code
    queue_cmd(FUNC_START, 32, 300, 32'h0);             // first index past the array
    queue_cmd(FUNC_START, 255, 300, 32'h0);
    queue_cmd(FUNC_START, 31, 300, 32'h8000_0000);     // top motor away from home
    queue_cmd(FUNC_START, 31, 65535, 32'h7FFF_FFFF);   // top motor starts
    queue_cmd(FUNC_TICK, 0, 0, 32'h7FFF_FFFF);
    queue_cmd(FUNC_START, 0, 250, 32'hFFFF_FFFE);      // restart on motor 0
    queue_cmd(FUNC_START, 40, 300, 32'h0);             // reject keeps the drive
    queue_cmd(FUNC_TICK, 0, 0, 32'h0);                 // ignored after a reject
    queue_cmd(FUNC_STOP, 0, 0, 32'h0);                 // status stays invalid
    queue_cmd(FUNC_START, 5, 249, 32'h0);              // default timeout
    queue_cmd(FUNC_STOP, 0, 0, 32'h0);                 // running becomes idle
    drain();

    // Count above the array size, zero filter and timeout, inverted drive.
    write_reg(CFG_MOTOR_COUNT, 16'hFFFF);
    write_reg(CFG_DEFAULT_TIMEOUT, 16'd0);
    write_reg(CFG_HOME_FILTER, 16'd0);
    write_reg(CFG_OUTPUT_HIGH, 16'hFFFE);
    write_reg(CFG_UNUSED, 16'hFFFF);
    queue_cmd(FUNC_TICK, 0, 0, 32'h0);                 // idle drive all ones
    queue_cmd(FUNC_START, 31, 0, 32'h0);
    queue_cmd(FUNC_TICK, 0, 0, 32'h0);                 // zero timeout expires
    queue_cmd(FUNC_START, 2, 300, 32'h0);
    queue_cmd(FUNC_TICK, 0, 0, 32'h4);                 // leaves home
    queue_cmd(FUNC_TICK, 0, 0, 32'h0);                 // back home: confirmed
    queue_cmd(FUNC_START, 10, 300, 32'h0);
    drain();
    // active motor drops out of the fitted range while running
    write_reg(CFG_MOTOR_COUNT, 16'd4);
    queue_cmd(FUNC_TICK, 0, 0, 32'h0);
    queue_cmd(FUNC_STOP, 0, 0, 32'h0);
    drain();

    // Random phases, each under its own settings.
    queued = 0;
    while (queued < RANDOM_CMDS) begin
      pick_settings();
      phase_end = queued + $urandom_range(60, 140);
      if (phase_end > RANDOM_CMDS) phase_end = RANDOM_CMDS;
      while (queued < phase_end) begin
        k = $urandom_range(0, 99);
        if (k < 75) begin
          queue_home_cycle();
        end else if (k < 85) begin
          queue_cmd(func_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end else if (k < 92) begin
          if (fitted() > 0 && $urandom_range(0, 1)) begin
            m = $urandom_range(0, fitted() - 1);
            queue_cmd(FUNC_START, m, request_tmo(), levels_for(m, 1'b0));
          end else begin
            queue_cmd(FUNC_START, $urandom_range(fitted(), 255), $urandom, $urandom);
          end
        end else begin
          queue_cmd(FUNC_STOP, $urandom, $urandom, $urandom);
        end
      end
      drain();
    end

    // Back to back, no stalls: a short filter lets one cycle leave home,
    // return and confirm with a transfer on every edge.
    write_reg(CFG_MOTOR_COUNT, 16'd32);
    write_reg(CFG_DEFAULT_TIMEOUT, 16'hFFFF);
    write_reg(CFG_HOME_FILTER, 16'd2);
    quiet = 1'b1;
    m = $urandom_range(0, 31);
    queue_cmd(FUNC_START, m, 65535, levels_for(m, 1'b1));
    for (k = 0; k < 40; k++) queue_cmd(FUNC_TICK, 0, 0, levels_for(m, !k[3]));
    queue_cmd(FUNC_STOP, 0, 0, 32'h0);
    drain();
    quiet = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
